@@ rtl/dod_pkg.sv @@
// ----------------------------------------------------------------------------
// dod_pkg
// Shared widths, word layouts and register indexes of the detection output
// decoder.
// ----------------------------------------------------------------------------
package dod_pkg;

   // field widths
   localparam int COORD_W   = 16;
   localparam int SIZE_W    = 15;
   localparam int SCORE_W   = 16;
   localparam int PAD_W     = 14;
   localparam int SCALE_W   = 16;
   localparam int LIMIT_W   = 16;
   localparam int CLASS_W   = 7;

   // request word: center_x, center_y, box_w, box_h, class_score (+2 pad bits)
   localparam int REQ_DATA_W = 80;
   // response word: left, top, width_out, height_out, best_score, best_class
   localparam int RSP_DATA_W = 88;

   // Q.5 corner before scaling, and its product with the Q4.12 scale
   localparam int E_W = 19;
   localparam int P_W = 36;
   // rounding offset and shift that take Q.17 back to Q.4
   localparam int RND_SHIFT = 13;
   localparam logic [P_W-1:0] ROUND_HALF = P_W'(4096);

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_CONF_THRESHOLD = 3'd0,
      REG_PAD_LEFT       = 3'd1,
      REG_PAD_TOP        = 3'd2,
      REG_INV_SCALE      = 3'd3,
      REG_IMAGE_WIDTH    = 3'd4,
      REG_IMAGE_HEIGHT   = 3'd5
   } csr_reg_type;

   localparam logic [SCORE_W-1:0] CONF_THRESHOLD_RST = 16'd16384;
   localparam logic [SCALE_W-1:0] INV_SCALE_RST      = 16'd4096;
   localparam logic [LIMIT_W-1:0] IMAGE_WIDTH_RST    = 16'd10240;
   localparam logic [LIMIT_W-1:0] IMAGE_HEIGHT_RST   = 16'd7680;

endpackage

@@ rtl/detection_output_decoder_core.sv @@
// ----------------------------------------------------------------------------
// detection_output_decoder_core
// Running argmax over the class scores of one anchor; on the anchor's last
// word the box is shifted, scaled, rounded and clamped and given out if the
// best score reaches the threshold.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         tvalid/tready        tdata: box and score, tlast: last_class
//  rsp      out        tvalid/tready        tdata: box, best score and class
//  csr      in         psel/penable/pready  six registers at 4*i, pready high
//
//  One word is taken every cycle while the response side drains. Words run
//  through four register stages (input, products, corners, response). The
//  four corner multipliers set the stage after the input register.
//  Reset is synchronous; it clears argmax state and valid bits, loads CSR defaults.
//  A stalled response holds every stage, and req_tready falls with it.
// ----------------------------------------------------------------------------
module detection_output_decoder_core
   import dod_pkg::*;
#(
   parameter int MAX_CLASSES = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   // center_x[15:0], center_y[31:16], box_w[46:32], box_h[61:47],
   // class_score[77:62], zeros[79:78]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // left[15:0], top[31:16], width_out[47:32], height_out[63:48],
   // best_score[79:64], best_class[86:80], zero[87]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

   // configuration registers
   logic [SCORE_W-1:0] conf_threshold_ff;
   logic [PAD_W-1:0]   pad_left_ff;
   logic [PAD_W-1:0]   pad_top_ff;
   logic [SCALE_W-1:0] inv_scale_ff;
   logic [LIMIT_W-1:0] image_width_ff;
   logic [LIMIT_W-1:0] image_height_ff;

   logic        csr_write;
   csr_reg_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_threshold_ff <= CONF_THRESHOLD_RST;
         pad_left_ff       <= '0;
         pad_top_ff        <= '0;
         inv_scale_ff      <= INV_SCALE_RST;
         image_width_ff    <= IMAGE_WIDTH_RST;
         image_height_ff   <= IMAGE_HEIGHT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_CONF_THRESHOLD: conf_threshold_ff <= csr_pwdata[SCORE_W-1:0];
            REG_PAD_LEFT:       pad_left_ff       <= csr_pwdata[PAD_W-1:0];
            REG_PAD_TOP:        pad_top_ff        <= csr_pwdata[PAD_W-1:0];
            REG_INV_SCALE:      inv_scale_ff      <= csr_pwdata[SCALE_W-1:0];
            REG_IMAGE_WIDTH:    image_width_ff    <= csr_pwdata[LIMIT_W-1:0];
            REG_IMAGE_HEIGHT:   image_height_ff   <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CONF_THRESHOLD: csr_prdata = CSR_DATA_W'(conf_threshold_ff);
         REG_PAD_LEFT:       csr_prdata = CSR_DATA_W'(pad_left_ff);
         REG_PAD_TOP:        csr_prdata = CSR_DATA_W'(pad_top_ff);
         REG_INV_SCALE:      csr_prdata = CSR_DATA_W'(inv_scale_ff);
         REG_IMAGE_WIDTH:    csr_prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT:   csr_prdata = CSR_DATA_W'(image_height_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // whole pipeline moves together whenever the response slot can take a word
   logic advance;
   logic rsp_valid_ff;

   assign advance    = ~rsp_valid_ff | rsp_tready;
   assign req_tready = advance;

   // ---------------------------------------------------------------- input
   logic                      s0_valid_ff;
   logic signed [COORD_W-1:0] s0_cx_ff;
   logic signed [COORD_W-1:0] s0_cy_ff;
   logic [SIZE_W-1:0]         s0_bw_ff;
   logic [SIZE_W-1:0]         s0_bh_ff;
   logic [SCORE_W-1:0]        s0_score_ff;
   logic                      s0_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_cx_ff    <= req_tdata[15:0];
         s0_cy_ff    <= req_tdata[31:16];
         s0_bw_ff    <= req_tdata[46:32];
         s0_bh_ff    <= req_tdata[61:47];
         s0_score_ff <= req_tdata[77:62];
         s0_last_ff  <= req_tlast;
      end
   end

   // ---------------------------------------------------------------- argmax
   logic [SCORE_W-1:0] running_best_ff,  running_best_in;
   logic [CNT_W-1:0]   running_class_ff, running_class_in;
   logic [CNT_W-1:0]   class_counter_ff, class_counter_in;
   logic [SCORE_W-1:0] best_new;
   logic [CNT_W-1:0]   class_new;
   logic [CNT_W:0]     count_inc;
   logic               emit;

   always_comb begin
      // strictly greater, so ties keep the earlier class
      if (s0_score_ff > running_best_ff) begin
         best_new  = s0_score_ff;
         class_new = class_counter_ff;
      end else begin
         best_new  = running_best_ff;
         class_new = running_class_ff;
      end
      count_inc = {1'b0, class_counter_ff} + 1'b1;
      if (s0_last_ff) begin
         running_best_in  = '0;
         running_class_in = '0;
         class_counter_in = '0;
      end else begin
         running_best_in  = best_new;
         running_class_in = class_new;
         if (count_inc >= (CNT_W+1)'(MAX_CLASSES)) begin
            class_counter_in = '0;
         end else begin
            class_counter_in = count_inc[CNT_W-1:0];
         end
      end
      emit = s0_valid_ff & s0_last_ff & (best_new >= conf_threshold_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_best_ff  <= '0;
         running_class_ff <= '0;
         class_counter_ff <= '0;
      end else if (advance && s0_valid_ff) begin
         running_best_ff  <= running_best_in;
         running_class_ff <= running_class_in;
         class_counter_ff <= class_counter_in;
      end
   end

   // ---------------------------------------------------------------- corners, Q.5 times Q4.12
   logic signed [E_W-1:0]   cx2, cy2, bw_s, bh_s, padl2, padt2;
   logic signed [E_W-1:0]   ex1, ex2, ey1, ey2;
   logic signed [SCALE_W:0] inv_s;
   logic signed [P_W-1:0]   px1, px2, py1, py2;

   assign cx2   = E_W'(s0_cx_ff) <<< 1;
   assign cy2   = E_W'(s0_cy_ff) <<< 1;
   assign bw_s  = signed'({{(E_W-SIZE_W){1'b0}}, s0_bw_ff});
   assign bh_s  = signed'({{(E_W-SIZE_W){1'b0}}, s0_bh_ff});
   assign padl2 = signed'({{(E_W-PAD_W-1){1'b0}}, pad_left_ff, 1'b0});
   assign padt2 = signed'({{(E_W-PAD_W-1){1'b0}}, pad_top_ff, 1'b0});
   assign ex1   = cx2 - bw_s - padl2;
   assign ex2   = cx2 + bw_s - padl2;
   assign ey1   = cy2 - bh_s - padt2;
   assign ey2   = cy2 + bh_s - padt2;
   assign inv_s = signed'({1'b0, inv_scale_ff});
   assign px1   = ex1 * inv_s;
   assign px2   = ex2 * inv_s;
   assign py1   = ey1 * inv_s;
   assign py2   = ey2 * inv_s;

   logic                  s1_valid_ff;
   logic signed [P_W-1:0] s1_px1_ff, s1_px2_ff, s1_py1_ff, s1_py2_ff;
   logic [SCORE_W-1:0]    s1_score_ff;
   logic [CLASS_W-1:0]    s1_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px1_ff   <= px1;
         s1_px2_ff   <= px2;
         s1_py1_ff   <= py1;
         s1_py2_ff   <= py2;
         s1_score_ff <= best_new;
         s1_class_ff <= CLASS_W'(class_new);
      end
   end

   // ---------------------------------------------------------------- round and clamp
   function automatic logic [LIMIT_W-1:0] clamp_corner(input logic signed [P_W-1:0] p,
                                                       input logic [LIMIT_W-1:0]    limit);
      logic [P_W-1:0]         sum;
      logic [P_W-RND_SHIFT-1:0] q;
      sum = unsigned'(p) + ROUND_HALF;
      q   = sum[P_W-1:RND_SHIFT];
      if (p <= 0) begin
         clamp_corner = '0;
      end else if (q > (P_W-RND_SHIFT)'(limit)) begin
         clamp_corner = limit;
      end else begin
         clamp_corner = q[LIMIT_W-1:0];
      end
   endfunction

   logic               s2_valid_ff;
   logic [LIMIT_W-1:0] s2_x1_ff, s2_x2_ff, s2_y1_ff, s2_y2_ff;
   logic [SCORE_W-1:0] s2_score_ff;
   logic [CLASS_W-1:0] s2_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_x1_ff    <= clamp_corner(s1_px1_ff, image_width_ff);
         s2_x2_ff    <= clamp_corner(s1_px2_ff, image_width_ff);
         s2_y1_ff    <= clamp_corner(s1_py1_ff, image_height_ff);
         s2_y2_ff    <= clamp_corner(s1_py2_ff, image_height_ff);
         s2_score_ff <= s1_score_ff;
         s2_class_ff <= s1_class_ff;
      end
   end

   // ---------------------------------------------------------------- response
   logic [LIMIT_W-1:0]    width_in, height_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign width_in  = (s2_x2_ff >= s2_x1_ff) ? s2_x2_ff - s2_x1_ff : '0;
   assign height_in = (s2_y2_ff >= s2_y1_ff) ? s2_y2_ff - s2_y1_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {1'b0, s2_class_ff, s2_score_ff, height_in, width_in,
                         s2_y1_ff, s2_x1_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ tb/sv/detection_output_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_output_decoder_core_tb
// Streams anchors of class scores into the decoder, predicts boxes from a
// bit-accurate model of the argmax, letterbox shift, scaling, rounding and
// clamping or takes them as given, and checks every response word in order. A
// directed table comes first, then random anchors over several register settings.
// ----------------------------------------------------------------------------
module detection_output_decoder_core_tb;
   import dod_pkg::*;

   localparam int NUM_CLASSES  = 128;
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_PERCENT = 13;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 190;
   localparam int STEADY_PHASE = 5;
   localparam int MAX_SHOWN    = 10;
   localparam int NUM_REGS     = 6;
   // index past the register file, writes to it must be dropped
   localparam logic [2:0] REG_SPARE = 3'd6;

   typedef struct packed {
      logic [15:0]        left;
      logic [15:0]        top;
      logic [15:0]        width;
      logic [15:0]        height;
      logic [15:0]        score;
      logic [CLASS_W-1:0] cls;
   } det_box_type;

   typedef enum logic [1:0] {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {OUT_PREDICTED, OUT_NONE, OUT_GIVEN} row_out_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   idx;
      logic [31:0]  value;
      logic [15:0]  cx;
      logic [15:0]  cy;
      logic [14:0]  bw;
      logic [14:0]  bh;
      logic [15:0]  score;
      logic         last;
      row_out_type  out;
      det_box_type  box;
   } row_type;

   localparam det_box_type NO_BOX = '0;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // register shadows
   logic [15:0] cfg_threshold = CONF_THRESHOLD_RST;
   logic [13:0] cfg_pad_left  = '0;
   logic [13:0] cfg_pad_top   = '0;
   logic [15:0] cfg_inv_scale = INV_SCALE_RST;
   logic [15:0] cfg_image_w   = IMAGE_WIDTH_RST;
   logic [15:0] cfg_image_h   = IMAGE_HEIGHT_RST;

   // argmax of the anchor in flight
   logic [15:0]        lead_score  = '0;
   logic [CLASS_W-1:0] lead_class  = '0;
   logic [CLASS_W-1:0] class_index = '0;

   det_box_type pending_boxes[$];
   row_type     plan[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          idle_on     = 1'b1;

   detection_output_decoder_core #(
      .MAX_CLASSES (NUM_CLASSES)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_SHOWN) begin
         $display("%s", msg);
      end
   endtask

   task automatic add_row(input row_type r);
      plan.insert(plan.size(), r);
   endtask

   task automatic expect_box(input det_box_type b);
      pending_boxes.insert(pending_boxes.size(), b);
   endtask

   function automatic det_box_type box_of(input logic [15:0] l, t, w, h, s,
                                          input logic [CLASS_W-1:0] c);
      det_box_type b;
      b = '{l, t, w, h, s, c};
      return b;
   endfunction

   function automatic row_type word_row(input logic [15:0] cx, cy, input logic [14:0] bw, bh,
                                        input logic [15:0] score, input logic last,
                                        input row_out_type out, input det_box_type box);
      row_type r;
      r = '{ROW_WORD, 3'd0, 32'd0, cx, cy, bw, bh, score, last, out, box};
      return r;
   endfunction

   function automatic row_type csr_row(input logic [2:0] idx, input logic [31:0] value);
      row_type r;
      r = '{ROW_CSR, idx, value, 16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 1'b0, OUT_NONE, NO_BOX};
      return r;
   endfunction

   // Q.5 corner times the Q4.12 scale, rounded half up to Q.4 and clamped
   function automatic logic [15:0] scale_corner(input longint e, input logic [15:0] limit);
      longint p;
      longint q;
      p = e * longint'(cfg_inv_scale);
      if (p <= 0) begin
         return '0;
      end
      q = (p + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (q > longint'(limit)) begin
         q = longint'(limit);
      end
      return q[15:0];
   endfunction

   task automatic track_anchor(input logic [15:0] cx, cy, input logic [14:0] bw, bh,
                               input logic [15:0] score, input logic last,
                               output logic hit, output det_box_type box);
      longint ex;
      longint ey;
      logic [15:0] x1;
      logic [15:0] x2;
      logic [15:0] y1;
      logic [15:0] y2;
      hit = 1'b0;
      box = NO_BOX;
      // strictly greater, so a tie keeps the earlier class
      if (score > lead_score) begin
         lead_score = score;
         lead_class = class_index;
      end
      class_index = (class_index == NUM_CLASSES - 1) ? '0 : class_index + 1'b1;
      if (!last) begin
         return;
      end
      ex = 2 * longint'($signed(cx)) - 2 * longint'(cfg_pad_left);
      ey = 2 * longint'($signed(cy)) - 2 * longint'(cfg_pad_top);
      x1 = scale_corner(ex - longint'(bw), cfg_image_w);
      x2 = scale_corner(ex + longint'(bw), cfg_image_w);
      y1 = scale_corner(ey - longint'(bh), cfg_image_h);
      y2 = scale_corner(ey + longint'(bh), cfg_image_h);
      hit = (lead_score >= cfg_threshold);
      box = '{x1, y1, (x2 >= x1) ? x2 - x1 : 16'd0, (y2 >= y1) ? y2 - y1 : 16'd0,
              lead_score, lead_class};
      lead_score  = '0;
      lead_class  = '0;
      class_index = '0;
   endtask

   // offers one word and returns on the edge that takes it, tvalid left high
   task automatic push_word(input logic [15:0] cx, cy, input logic [14:0] bw, bh,
                            input logic [15:0] score, input logic last,
                            input row_out_type out, input det_box_type given);
      logic        hit;
      det_box_type box;
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= {2'b00, score, bh, bw, cy, cx};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      track_anchor(cx, cy, bw, bh, score, last, hit, box);
      case (out)
         OUT_PREDICTED: begin
            if (hit) begin
               expect_box(box);
            end
         end
         OUT_GIVEN: begin
            expect_box(given);
         end
         default: begin
         end
      endcase
   endtask

   // stop the stream and let the pipeline empty before touching registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      case (idx)
         REG_CONF_THRESHOLD: cfg_threshold = value[15:0];
         REG_PAD_LEFT:       cfg_pad_left  = value[13:0];
         REG_PAD_TOP:        cfg_pad_top   = value[13:0];
         REG_INV_SCALE:      cfg_inv_scale = value[15:0];
         REG_IMAGE_WIDTH:    cfg_image_w   = value[15:0];
         REG_IMAGE_HEIGHT:   cfg_image_h   = value[15:0];
         default: begin
         end
      endcase
      if (idx <= REG_IMAGE_HEIGHT) begin
         // read back, held value is masked to the register width
         csr_pwrite  <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) begin
            @(posedge clock);
         end
         case (idx)
            REG_CONF_THRESHOLD: want = 32'(cfg_threshold);
            REG_PAD_LEFT:       want = 32'(cfg_pad_left);
            REG_PAD_TOP:        want = 32'(cfg_pad_top);
            REG_INV_SCALE:      want = 32'(cfg_inv_scale);
            REG_IMAGE_WIDTH:    want = 32'(cfg_image_w);
            default:            want = 32'(cfg_image_h);
         endcase
         if (csr_prdata !== want) begin
            note_error($sformatf("register %0d read back: expected %0d, got %0d",
                                 idx, want, csr_prdata));
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // response side: check each word, then stall at random
   always @(posedge clock) begin
      det_box_type got;
      det_box_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tdata[63:48],
                 rsp_tdata[79:64], rsp_tdata[86:80]};
         if (pending_boxes.size() == 0) begin
            note_error($sformatf("box word with nothing expected: l=%0d t=%0d w=%0d h=%0d",
                                 got.left, got.top, got.width, got.height));
         end else begin
            want = pending_boxes.pop_front();
            if (got !== want) begin
               note_error($sformatf({"box mismatch: expected l=%0d t=%0d w=%0d h=%0d ",
                                     "s=%0d c=%0d, got l=%0d t=%0d w=%0d h=%0d s=%0d c=%0d"},
                                    want.left, want.top, want.width, want.height,
                                    want.score, want.cls, got.left, got.top, got.width,
                                    got.height, got.score, got.cls));
            end
         end
      end
      rsp_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      row_type     r;
      logic [31:0] vals[NUM_REGS];
      logic [15:0] tie_score;
      logic [15:0] score;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [14:0] bw;
      logic [14:0] bh;
      int          words;
      int          n;
      int          pick;

      // box A: centre (100, 50), size (20, 10) in model pixels
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'hFFFF, 1'b1, OUT_GIVEN,
                       box_of(16'd1440, 16'd720, 16'd320, 16'd160, 16'hFFFF, 7'd0)));
      // just under and exactly at the threshold
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'd16383, 1'b1, OUT_NONE,
                       NO_BOX));
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'd16384, 1'b1, OUT_GIVEN,
                       box_of(16'd1440, 16'd720, 16'd320, 16'd160, 16'd16384, 7'd0)));
      // tie on the third class keeps the second
      add_row(word_row(16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'd100, 1'b0, OUT_NONE,
                       NO_BOX));
      add_row(word_row(16'd0, 16'd0, 15'd0, 15'd0, 16'd40000, 1'b0, OUT_NONE, NO_BOX));
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'd40000, 1'b1, OUT_GIVEN,
                       box_of(16'd1440, 16'd720, 16'd320, 16'd160, 16'd40000, 7'd1)));
      // most negative centre, every corner below zero
      add_row(word_row(16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF, 16'hFFFF, 1'b1, OUT_GIVEN,
                       box_of(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 7'd0)));
      // largest centre and size, clamped to the image
      add_row(word_row(16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 1'b1, OUT_GIVEN,
                       box_of(16'd10240, 16'd7680, 16'd0, 16'd0, 16'hFFFF, 7'd0)));
      // all scores zero with a zero threshold
      add_row(csr_row(REG_CONF_THRESHOLD, 32'd0));
      add_row(word_row(16'd0, 16'd0, 15'd0, 15'd0, 16'd0, 1'b0, OUT_NONE, NO_BOX));
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'd0, 1'b1, OUT_GIVEN,
                       box_of(16'd1440, 16'd720, 16'd320, 16'd160, 16'd0, 7'd0)));
      // zero reciprocal scale flattens the box
      add_row(csr_row(REG_INV_SCALE, 32'd0));
      add_row(word_row(16'd1600, 16'd800, 15'd320, 15'd160, 16'd500, 1'b1, OUT_GIVEN,
                       box_of(16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 7'd0)));
      // upper extremes, wide writes are masked, the spare index is dropped
      add_row(csr_row(REG_SPARE, 32'hFFFF_FFFF));
      add_row(csr_row(REG_CONF_THRESHOLD, 32'hFFFF_FFFF));
      add_row(csr_row(REG_PAD_LEFT, 32'hFFFF_FFFF));
      add_row(csr_row(REG_PAD_TOP, 32'hFFFF_FFFF));
      add_row(csr_row(REG_INV_SCALE, 32'hFFFF_FFFF));
      add_row(csr_row(REG_IMAGE_WIDTH, 32'hFFFF_FFFF));
      add_row(csr_row(REG_IMAGE_HEIGHT, 32'hFFFF_FFFF));
      add_row(word_row(16'h7FFF, 16'h7FFF, 15'd0, 15'h7FFF, 16'hFFFF, 1'b1,
                       OUT_PREDICTED, NO_BOX));
      add_row(word_row(16'd12000, 16'd9000, 15'd500, 15'd3000, 16'hFFFE, 1'b1, OUT_NONE,
                       NO_BOX));
      add_row(word_row(16'd5, 16'd5, 15'd7, 15'd7, 16'hFFFF, 1'b0, OUT_NONE, NO_BOX));
      add_row(word_row(16'd12000, 16'd9000, 15'd500, 15'd3000, 16'hFFFF, 1'b1,
                       OUT_PREDICTED, NO_BOX));
      add_row(word_row(16'h8001, 16'd8192, 15'd1, 15'd0, 16'hFFFF, 1'b1,
                       OUT_PREDICTED, NO_BOX));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         r = plan[i];
         if (r.kind == ROW_CSR) begin
            settle();
            write_reg(r.idx, r.value);
         end else begin
            push_word(r.cx, r.cy, r.bw, r.bh, r.score, r.last, r.out, r.box);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: vals = '{32'(CONF_THRESHOLD_RST), 32'd0, 32'd0, 32'(INV_SCALE_RST),
                        32'(IMAGE_WIDTH_RST), 32'(IMAGE_HEIGHT_RST)};
            1: vals = '{default: 32'hFFFF_FFFF};
            2: vals = '{default: 32'd0};
            default: begin
               vals[REG_CONF_THRESHOLD] = $urandom_range(0, 40000);
               vals[REG_PAD_LEFT] = $urandom_range(0, 1) ? $urandom_range(0, 16383)
                                                         : $urandom_range(0, 1200);
               vals[REG_PAD_TOP] = $urandom_range(0, 1) ? $urandom_range(0, 16383)
                                                        : $urandom_range(0, 1200);
               vals[REG_INV_SCALE] = ($urandom_range(0, 3) == 0) ? $urandom()
                                                                 : $urandom_range(2048, 12288);
               vals[REG_IMAGE_WIDTH] = $urandom_range(0, 1) ? $urandom()
                                                            : $urandom_range(4096, 30720);
               vals[REG_IMAGE_HEIGHT] = $urandom_range(0, 1) ? $urandom()
                                                             : $urandom_range(4096, 17280);
            end
         endcase
         settle();
         for (int k = 0; k < NUM_REGS; k++) begin
            write_reg(3'(k), vals[k]);
         end
         idle_on = (phase != STEADY_PHASE);

         words = 0;
         while (words < PHASE_WORDS) begin
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
               n = $urandom_range(NUM_CLASSES + 1, NUM_CLASSES + 32);   // class index wraps
            end else if (pick < 8) begin
               n = $urandom_range(9, 40);
            end else begin
               n = $urandom_range(1, 8);
            end
            tie_score = 16'($urandom());
            for (int c = 0; c < n; c++) begin
               case ($urandom_range(0, 9))
                  0, 1:    score = tie_score;
                  2:       score = '0;
                  3:       score = '1;
                  default: score = 16'($urandom());
               endcase
               cx = 16'($urandom());
               cy = 16'($urandom());
               bw = 15'($urandom());
               bh = 15'($urandom());
               // realistic boxes on about half the last words, raw noise elsewhere
               if (c == n - 1 && $urandom_range(0, 1)) begin
                  cx = 16'($urandom_range(0, 10240));
                  cy = 16'($urandom_range(0, 10240));
                  bw = 15'($urandom_range(0, 4000));
                  bh = 15'($urandom_range(0, 4000));
               end
               push_word(cx, cy, bw, bh, score, c == n - 1, OUT_PREDICTED, NO_BOX);
               words++;
            end
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dod_pkg.sv
rtl/detection_output_decoder_core.sv
tb/sv/detection_output_decoder_core_tb.sv
